>>> src/assert_macros.svh
// Assertion macros used by the execute unit back end (a64x_exec).
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication: the consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/a64x_pkg.sv
// Package for the execute unit: opcode constants, op classes, queue word type.
// No dependencies.
package a64x_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [10:0] OpHlt  = 11'h6a2;
  localparam logic [10:0] OpAdd  = 11'h458;
  localparam logic [10:0] OpAdds = 11'h558;
  localparam logic [10:0] OpSub  = 11'h658;
  localparam logic [10:0] OpSubs = 11'h758;
  localparam logic [10:0] OpMul  = 11'h4d8;
  localparam logic [10:0] OpMovz = 11'h694;
  localparam logic [9:0]  OpShf  = 10'h34d;
  localparam logic [8:0]  OpLdur = 9'h1c2;
  localparam logic [8:0]  OpStur = 9'h1c0;
  localparam logic [10:0] OpBr   = 11'h6b0;
  localparam logic [7:0]  OpAnd  = 8'h8a;
  localparam logic [7:0]  OpAnds = 8'hea;
  localparam logic [7:0]  OpEor  = 8'hca;
  localparam logic [7:0]  OpOrr  = 8'haa;
  localparam logic [7:0]  OpAddi = 8'h91;
  localparam logic [7:0]  OpAddis = 8'hb1;
  localparam logic [7:0]  OpSubi = 8'hd1;
  localparam logic [7:0]  OpSubis = 8'hf1;
  localparam logic [7:0]  OpBcond = 8'h54;
  localparam logic [7:0]  OpCbz  = 8'hb4;
  localparam logic [7:0]  OpCbnz = 8'hb5;
  localparam logic [5:0]  OpB    = 6'h05;

  localparam logic [4:0] CondEq = 5'h00;
  localparam logic [4:0] CondNe = 5'h01;
  localparam logic [4:0] CondGe = 5'h0a;
  localparam logic [4:0] CondLt = 5'h0b;
  localparam logic [4:0] CondGt = 5'h0c;
  localparam logic [4:0] CondLe = 5'h0d;

  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;

  typedef enum logic [4:0] {
    CL_HLT, CL_ADD, CL_SUB, CL_MUL, CL_MOVZ, CL_SHF, CL_LDUR, CL_STUR,
    CL_BR, CL_AND, CL_EOR, CL_ORR, CL_BCOND, CL_CBZ, CL_CBNZ, CL_B, CL_UNK
  } op_class_e;

  // Classified word handed from front to back.
  typedef struct packed {
    op_class_e   cls;
    logic        set_flags;
    logic        use_imm;
    logic        zero_rd31;
    logic [31:0] instruction;
    logic [63:0] instr_addr;
    logic [63:0] rn_value;
    logic [63:0] rm_value;
    logic [63:0] rt_value;
    logic [63:0] mul_lo;     // low halves product
    logic [31:0] mul_cross;  // cross products, low 32 bits
  } dec_word_t;

endpackage

>>> src/arm64_subset_execute_unit_core.sv
// Top level of the execute unit: front decode, queue, back execute.
// Depends on a64x_pkg, a64x_decode, a64x_queue, a64x_exec.
//
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   instruction, instr_addr, rn/rm/rt values
// out      output     out_valid_o/out_ready_i result fields and flags
//
// One word per cycle sustained while out_ready_i is high; each word passes
// through the front register, a queue entry and the back result register.
// The front end forms the 32x32 partial products of MUL and the back end
// adds them. Reset clears valids and the N/Z flags. A stall on the output
// fills the queue before the front end drops in_ready_o.
module arm64_subset_execute_unit_core #(
  parameter int unsigned QueueDepth = a64x_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [63:0] instr_addr_i,
  input  logic [63:0] rn_value_i,
  input  logic [63:0] rm_value_i,
  input  logic [63:0] rt_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_value_o,
  output logic [4:0]  dest_reg_o,
  output logic        reg_write_o,
  output logic [1:0]  mem_op_o,
  output logic [1:0]  access_size_o,
  output logic [63:0] address_o,
  output logic        branch_taken_o,
  output logic        halt_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        unknown_op_o
);

  a64x_pkg::dec_word_t dec_word, q_word;
  logic dec_valid, dec_ready, q_valid, q_ready;

  a64x_decode u_decode (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .instruction_i, .instr_addr_i,
    .rn_value_i, .rm_value_i, .rt_value_i,
    .dec_valid_o(dec_valid), .dec_ready_i(dec_ready), .dec_word_o(dec_word)
  );

  a64x_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(dec_valid), .wr_ready_o(dec_ready), .wr_word_i(dec_word),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_word_o(q_word)
  );

  a64x_exec u_exec (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_word_i(q_word),
    .out_valid_o, .out_ready_i, .result_value_o, .dest_reg_o, .reg_write_o,
    .mem_op_o, .access_size_o, .address_o, .branch_taken_o, .halt_o,
    .flag_n_o, .flag_z_o, .unknown_op_o
  );

endmodule

>>> src/a64x_decode.sv
// Front end: accepts an instruction word and classifies its opcode.
// Depends on a64x_pkg.
module a64x_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          instruction_i,
  input  logic [63:0]          instr_addr_i,
  input  logic [63:0]          rn_value_i,
  input  logic [63:0]          rm_value_i,
  input  logic [63:0]          rt_value_i,
  output logic                 dec_valid_o,
  input  logic                 dec_ready_i,
  output a64x_pkg::dec_word_t  dec_word_o
);

  logic [10:0] op11;
  logic [7:0]  op8;
  a64x_pkg::dec_word_t word_d, word_q;
  logic valid_q;

  assign op11 = instruction_i[31:21];
  assign op8  = instruction_i[31:24];

  // Opcode priority follows the order of the checks below; the first match wins.
  always_comb begin
    word_d = '0;
    word_d.instruction = instruction_i;
    word_d.instr_addr  = instr_addr_i;
    word_d.rn_value    = rn_value_i;
    word_d.rm_value    = rm_value_i;
    word_d.rt_value    = rt_value_i;
    // 32x32 partial products; the back end sums them for MUL
    word_d.mul_lo    = {32'd0, rn_value_i[31:0]} * {32'd0, rm_value_i[31:0]};
    word_d.mul_cross = rn_value_i[31:0] * rm_value_i[63:32]
                     + rn_value_i[63:32] * rm_value_i[31:0];
    if (op11 == a64x_pkg::OpHlt) word_d.cls = a64x_pkg::CL_HLT;
    else if (op11 == a64x_pkg::OpAdd) word_d.cls = a64x_pkg::CL_ADD;
    else if (op11 == a64x_pkg::OpAdds) begin
      word_d.cls = a64x_pkg::CL_ADD; word_d.set_flags = 1'b1;
    end else if (op11 == a64x_pkg::OpSub) word_d.cls = a64x_pkg::CL_SUB;
    else if (op11 == a64x_pkg::OpSubs) begin
      word_d.cls = a64x_pkg::CL_SUB; word_d.set_flags = 1'b1; word_d.zero_rd31 = 1'b1;
    end else if (op11 == a64x_pkg::OpMul) word_d.cls = a64x_pkg::CL_MUL;
    else if (op11 == a64x_pkg::OpMovz) word_d.cls = a64x_pkg::CL_MOVZ;
    else if (op11[10:1] == a64x_pkg::OpShf) word_d.cls = a64x_pkg::CL_SHF;
    else if (op11[8:0] == a64x_pkg::OpLdur) word_d.cls = a64x_pkg::CL_LDUR;
    else if (op11[8:0] == a64x_pkg::OpStur) word_d.cls = a64x_pkg::CL_STUR;
    else if (op11 == a64x_pkg::OpBr) word_d.cls = a64x_pkg::CL_BR;
    else if (op8 == a64x_pkg::OpAnd) word_d.cls = a64x_pkg::CL_AND;
    else if (op8 == a64x_pkg::OpAnds) begin
      word_d.cls = a64x_pkg::CL_AND; word_d.set_flags = 1'b1;
    end else if (op8 == a64x_pkg::OpEor) word_d.cls = a64x_pkg::CL_EOR;
    else if (op8 == a64x_pkg::OpOrr) word_d.cls = a64x_pkg::CL_ORR;
    else if (op8 == a64x_pkg::OpAddi) begin
      word_d.cls = a64x_pkg::CL_ADD; word_d.use_imm = 1'b1;
    end else if (op8 == a64x_pkg::OpAddis) begin
      word_d.cls = a64x_pkg::CL_ADD; word_d.use_imm = 1'b1; word_d.set_flags = 1'b1;
    end else if (op8 == a64x_pkg::OpSubi) begin
      word_d.cls = a64x_pkg::CL_SUB; word_d.use_imm = 1'b1;
    end else if (op8 == a64x_pkg::OpSubis) begin
      word_d.cls = a64x_pkg::CL_SUB; word_d.use_imm = 1'b1;
      word_d.set_flags = 1'b1; word_d.zero_rd31 = 1'b1;
    end else if (op8 == a64x_pkg::OpBcond) word_d.cls = a64x_pkg::CL_BCOND;
    else if (op8 == a64x_pkg::OpCbz) word_d.cls = a64x_pkg::CL_CBZ;
    else if (op8 == a64x_pkg::OpCbnz) word_d.cls = a64x_pkg::CL_CBNZ;
    else if (instruction_i[31:26] == a64x_pkg::OpB) word_d.cls = a64x_pkg::CL_B;
    else word_d.cls = a64x_pkg::CL_UNK;
  end

  assign in_ready_o  = !valid_q || dec_ready_i;
  assign dec_valid_o = valid_q;
  assign dec_word_o  = word_q;

  // Output register of the front end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_d;
    end
  end

endmodule

>>> src/a64x_queue.sv
// Short FIFO of classified words between front and back end.
// Depends on a64x_pkg.
module a64x_queue #(
  parameter int unsigned Depth = a64x_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  a64x_pkg::dec_word_t  wr_word_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output a64x_pkg::dec_word_t  rd_word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  a64x_pkg::dec_word_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_word_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(Depth-1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PtrW'(Depth-1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_word_i;
  end

endmodule

>>> src/a64x_exec.sv
// Back end: executes one classified word, keeps N/Z, registers the result.
// Depends on a64x_pkg and assert_macros.svh.
`include "assert_macros.svh"
module a64x_exec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  a64x_pkg::dec_word_t  q_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          result_value_o,
  output logic [4:0]           dest_reg_o,
  output logic                 reg_write_o,
  output logic [1:0]           mem_op_o,
  output logic [1:0]           access_size_o,
  output logic [63:0]          address_o,
  output logic                 branch_taken_o,
  output logic                 halt_o,
  output logic                 flag_n_o,
  output logic                 flag_z_o,
  output logic                 unknown_op_o
);

  logic [31:0] ins;
  logic [63:0] rn, rm, rt, pc, opb, sum, diff, off19, off26, imm9;
  logic [5:0]  immr, imms, lsl_amt;
  logic [4:0]  rd;
  logic        cond;
  logic        n_q, z_q, n_d, z_d;
  logic        valid_q, fire;
  logic [63:0] res_d, addr_d;
  logic [4:0]  dest_d;
  logic        wr_d, taken_d, halt_d, unk_d;
  logic [1:0]  mop_d, size_d;

  assign ins  = q_word_i.instruction;
  assign rn   = q_word_i.rn_value;
  assign rm   = q_word_i.rm_value;
  assign rt   = q_word_i.rt_value;
  assign pc   = q_word_i.instr_addr;
  assign rd   = ins[4:0];
  assign immr = ins[21:16];
  assign imms = ins[15:10];
  assign lsl_amt = 6'd0 - immr;
  assign opb  = q_word_i.use_imm ? {52'd0, ins[21:10]} : rm;
  assign sum  = rn + opb;
  assign diff = rn - opb;
  assign imm9  = {{55{ins[20]}}, ins[20:12]};
  assign off19 = {{43{ins[23]}}, ins[23:5], 2'b00};
  assign off26 = {{36{ins[25]}}, ins[25:0], 2'b00};

  // Condition check on the held flags.
  always_comb begin
    case (rd)
      a64x_pkg::CondEq: cond = z_q;
      a64x_pkg::CondNe: cond = !z_q;
      a64x_pkg::CondGe: cond = !n_q;
      a64x_pkg::CondLt: cond = n_q;
      a64x_pkg::CondGt: cond = !z_q && !n_q;
      a64x_pkg::CondLe: cond = z_q || n_q;
      default:          cond = 1'b0;
    endcase
  end

  // Execute by class.
  always_comb begin
    res_d = '0; addr_d = '0; dest_d = '0; wr_d = 1'b0; taken_d = 1'b0;
    halt_d = 1'b0; unk_d = 1'b0; mop_d = a64x_pkg::MemNone; size_d = '0;
    case (q_word_i.cls)
      a64x_pkg::CL_HLT:  halt_d = 1'b1;
      a64x_pkg::CL_ADD:  res_d = sum;
      a64x_pkg::CL_SUB:  res_d = diff;
      // low 64 bits of the product from the front-end partial products
      a64x_pkg::CL_MUL:  res_d = q_word_i.mul_lo + {q_word_i.mul_cross, 32'd0};
      a64x_pkg::CL_MOVZ: res_d = {48'd0, ins[20:5]};
      a64x_pkg::CL_SHF:  res_d = (imms == 6'h3f) ? (rn >> immr) : (rn << lsl_amt);
      a64x_pkg::CL_AND:  res_d = rn & rm;
      a64x_pkg::CL_EOR:  res_d = rn ^ rm;
      a64x_pkg::CL_ORR:  res_d = rn | rm;
      a64x_pkg::CL_LDUR: begin
        mop_d = a64x_pkg::MemLoad; size_d = ins[31:30]; addr_d = rn + imm9;
        dest_d = rd; wr_d = 1'b1;
      end
      a64x_pkg::CL_STUR: begin
        mop_d = a64x_pkg::MemStore; size_d = ins[31:30]; addr_d = rn + imm9; res_d = rt;
      end
      a64x_pkg::CL_BR: begin
        taken_d = 1'b1; addr_d = rn;
      end
      a64x_pkg::CL_BCOND: if (cond) begin
        taken_d = 1'b1; addr_d = pc + off19;
      end
      a64x_pkg::CL_CBZ: if (rt == '0) begin
        taken_d = 1'b1; addr_d = pc + off19;
      end
      a64x_pkg::CL_CBNZ: if (rt != '0) begin
        taken_d = 1'b1; addr_d = pc + off19;
      end
      a64x_pkg::CL_B: begin
        taken_d = 1'b1; addr_d = pc + off26;
      end
      default: unk_d = 1'b1;
    endcase
    if (q_word_i.cls inside {a64x_pkg::CL_ADD, a64x_pkg::CL_SUB, a64x_pkg::CL_MUL,
                             a64x_pkg::CL_MOVZ, a64x_pkg::CL_SHF, a64x_pkg::CL_AND,
                             a64x_pkg::CL_EOR, a64x_pkg::CL_ORR}) begin
      dest_d = rd; wr_d = 1'b1;
    end
    n_d = n_q; z_d = z_q;
    if (q_word_i.set_flags) begin
      n_d = res_d[63]; z_d = (res_d == '0);
    end
    if (q_word_i.zero_rd31 && rd == 5'd31) res_d = '0;
  end

  assign q_ready_o = !valid_q || out_ready_i;
  assign fire = q_valid_i && q_ready_o;
  assign out_valid_o = valid_q;

  // Flags and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= 1'b0; z_q <= 1'b0; valid_q <= 1'b0;
    end else begin
      if (q_ready_o) valid_q <= q_valid_i;
      if (fire) begin
        n_q <= n_d; z_q <= z_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_value_o <= res_d; dest_reg_o <= dest_d; reg_write_o <= wr_d;
      mem_op_o <= mop_d; access_size_o <= size_d; address_o <= addr_d;
      branch_taken_o <= taken_d; halt_o <= halt_d; flag_n_o <= n_d;
      flag_z_o <= z_d; unknown_op_o <= unk_d;
    end
  end

  `ASSERT_NEXT(a_flags_hold, clk_i, rst_ni, !fire, $stable(n_q) && $stable(z_q))
  `ASSERT_NEXT(a_out_flags, clk_i, rst_ni, fire, flag_n_o == n_q && flag_z_o == z_q)
  `ASSERT_CLK(a_one_kind, clk_i, rst_ni,
    !valid_q || $countones({halt_o, unknown_op_o, branch_taken_o,
                            mem_op_o != a64x_pkg::MemNone}) <= 1)

endmodule
